// ===== design/qph_pkg.sv =====
// ----------------------------------------------------------------------------
// qph_pkg
// Types and codes shared by the quadratic probe hash table core.
// ----------------------------------------------------------------------------
package qph_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] KIND_EMPTY = 2'd0;
  localparam logic [1:0] KIND_USED  = 2'd1;
  localparam logic [1:0] KIND_TOMB  = 2'd2;

  localparam logic [63:0] HASH_SEED = 64'd5381;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [63:0] value;
    logic [3:0]  value_len;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_value;
    logic [3:0]  found_len;
    logic [9:0]  slot_index;
  } out_t;

  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [63:0] value;
    logic [3:0]  value_len;
  } slot_t;

endpackage

// ===== design/qph_hash.sv =====
// ----------------------------------------------------------------------------
// qph_hash
// djb2 hash, one key byte per cycle, then reduction modulo the table length,
// four hash bits per cycle.
// ----------------------------------------------------------------------------
module qph_hash #(
  parameter int SLOT_COUNT = 1021,
  parameter int IW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   key,
  input  logic [3:0]    key_len,
  output logic          done,
  output logic [IW-1:0] index
);

  typedef enum logic [1:0] {HS_IDLE, HS_BYTE, HS_MOD} hs_state_t;

  localparam logic [IW:0] TL = (IW+1)'(SLOT_COUNT);

  hs_state_t     state;
  logic [63:0]   h;
  logic [3:0]    cnt;
  logic [IW-1:0] rem;
  logic [IW-1:0] rem_next;
  logic [7:0]    byte_sel;

  assign byte_sel = key[{cnt[2:0], 3'b000} +: 8];

  always_comb begin
    logic [IW:0] t;
    t = {1'b0, rem};
    for (int b = 3; b >= 0; b--) begin
      t = {t[IW-1:0], h[60+b]};
      if (t >= TL) t = t - TL;
    end
    rem_next = t[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HS_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == HS_MOD) && (cnt == 4'd15);
      case (state)
        HS_IDLE: begin
          if (start) begin
            h     <= qph_pkg::HASH_SEED;
            cnt   <= 4'd0;
            state <= HS_BYTE;
          end
        end
        HS_BYTE: begin
          if (cnt == key_len) begin
            rem   <= '0;
            cnt   <= 4'd0;
            state <= HS_MOD;
          end else begin
            h   <= (h << 5) + h + {56'd0, byte_sel};
            cnt <= cnt + 4'd1;
          end
        end
        HS_MOD: begin
          rem <= rem_next;
          h   <= {h[59:0], 4'b0000};
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            index <= rem_next;
            state <= HS_IDLE;
          end
        end
        default: state <= HS_IDLE;
      endcase
    end
  end

endmodule

// ===== design/qph_slot_mem.sv =====
// ----------------------------------------------------------------------------
// qph_slot_mem
// Slot kind and slot payload memories, one shared address, registered read.
// ----------------------------------------------------------------------------
module qph_slot_mem #(
  parameter int DEPTH = 1021,
  parameter int AW = 10
) (
  input  logic            clk,
  input  logic [AW-1:0]   addr,
  input  logic            kind_we,
  input  logic [1:0]      kind_wdata,
  input  logic            data_we,
  input  qph_pkg::slot_t  data_wdata,
  output logic [1:0]      kind_rdata,
  output qph_pkg::slot_t  data_rdata
);

  logic [1:0]     kind_mem [DEPTH];
  qph_pkg::slot_t data_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (kind_we) kind_mem[addr] <= kind_wdata;
    kind_rdata <= kind_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (data_we) data_mem[addr] <= data_wdata;
    data_rdata <= data_mem[addr];
  end

endmodule

// ===== design/quadratic_probe_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_core
// Open-addressing key-value store, djb2 hash, quadratic probing, tombstones.
// ----------------------------------------------------------------------------
// Steps: hash the key bytes, reduce the hash modulo the table length, then for
// each probe a slot memory read, then compare/write, then the output handshake.
// One item at a time: a new beat is accepted only once the last result has gone to the output register.
// Inserts at the fill limit (half the slots used) and unknown ops skip hashing and probing and go straight to S_FIN.
// Reset: a clearing pass over all SLOT_COUNT slots marks every slot empty;
// no beat is accepted until it ends.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_core #(
  parameter int SLOT_COUNT = 1021,
  parameter int KEY_BYTES = 8,
  parameter int VALUE_BYTES = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  qph_pkg::in_t  in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output qph_pkg::out_t out_item
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam logic [IW:0]   TL    = (IW+1)'(SLOT_COUNT);
  localparam logic [IW-1:0] TLAST = IW'(SLOT_COUNT - 1);
  localparam logic [IW-1:0] HALF  = IW'(SLOT_COUNT / 2);
  localparam logic [3:0]    KB    = 4'(KEY_BYTES);
  localparam logic [3:0]    VB    = 4'(VALUE_BYTES);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_READ, S_EVAL, S_FIN} state_t;

  state_t         state;
  logic [IW-1:0]  clr_idx;
  logic [1:0]     op;
  logic [63:0]    k;
  logic [3:0]     klen;
  logic [63:0]    v;
  logic [3:0]     vlen;
  logic [IW-1:0]  idx;
  logic [IW-1:0]  step;
  logic [IW-1:0]  probe;
  logic [IW-1:0]  count;
  logic           hash_start;
  logic           hash_done;
  logic [IW-1:0]  hash_index;
  qph_pkg::out_t  res;

  logic [3:0]     klen_in, vlen_in;
  logic [63:0]    kmask, vmask;
  logic [IW:0]    idx_sum, step_sum;
  logic [IW-1:0]  idx_next, step_next;
  logic           ins_full, op_bad;

  logic [IW-1:0]  mem_addr;
  logic           kind_we, data_we;
  logic [1:0]     kind_wdata;
  qph_pkg::slot_t data_wdata;
  logic [1:0]     kind_rdata;
  qph_pkg::slot_t data_rdata;

  logic           is_match, take_slot, last_probe;

  assign klen_in = (in_item.key_len > KB) ? KB : in_item.key_len;
  assign vlen_in = (in_item.value_len > VB) ? VB : in_item.value_len;

  assign ins_full = (in_item.op == qph_pkg::OP_INSERT) && (count >= HALF);
  assign op_bad   = (in_item.op != qph_pkg::OP_INSERT) &&
                    (in_item.op != qph_pkg::OP_REMOVE) &&
                    (in_item.op != qph_pkg::OP_LOOKUP);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      kmask[i*8 +: 8] = (4'(i) < klen_in) ? 8'hFF : 8'h00;
      vmask[i*8 +: 8] = (4'(i) < vlen_in) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    idx_sum  = {1'b0, idx} + {1'b0, step};
    idx_next = (idx_sum >= TL) ? IW'(idx_sum - TL) : idx_sum[IW-1:0];
    step_sum = {1'b0, step} + (IW+1)'(2);
    step_next = (step_sum >= TL) ? IW'(step_sum - TL) : step_sum[IW-1:0];
  end

  assign in_ready   = (state == S_IDLE);
  assign is_match   = (kind_rdata == qph_pkg::KIND_USED) &&
                      (data_rdata.key_len == klen) && (data_rdata.key == k);
  assign take_slot  = (kind_rdata != qph_pkg::KIND_USED);
  assign last_probe = (probe == TLAST);

  assign mem_addr   = (state == S_CLEAR) ? clr_idx : idx;
  assign kind_wdata = (state == S_CLEAR) ? qph_pkg::KIND_EMPTY :
                      (op == qph_pkg::OP_INSERT) ? qph_pkg::KIND_USED : qph_pkg::KIND_TOMB;
  assign data_we    = (state == S_EVAL) && (op == qph_pkg::OP_INSERT) && take_slot;
  assign kind_we    = (state == S_CLEAR) || data_we ||
                      ((state == S_EVAL) && (op == qph_pkg::OP_REMOVE) && is_match &&
                       (kind_rdata != qph_pkg::KIND_EMPTY));
  assign data_wdata = '{key: k, key_len: klen, value: v, value_len: vlen};

  qph_hash #(.SLOT_COUNT(SLOT_COUNT), .IW(IW)) u_hash (
    .clk     (clk),
    .rst     (rst),
    .start   (hash_start),
    .key     (k),
    .key_len (klen),
    .done    (hash_done),
    .index   (hash_index)
  );

  qph_slot_mem #(.DEPTH(SLOT_COUNT), .AW(IW)) u_mem (
    .clk        (clk),
    .addr       (mem_addr),
    .kind_we    (kind_we),
    .kind_wdata (kind_wdata),
    .data_we    (data_we),
    .data_wdata (data_wdata),
    .kind_rdata (kind_rdata),
    .data_rdata (data_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
      hash_start <= 1'b0;
    end else begin
      hash_start <= (state == S_IDLE) && in_valid && !ins_full && !op_bad;
      out_valid  <= (state == S_FIN) || (out_valid && !out_ready);
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == TLAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op   <= in_item.op;
            k    <= in_item.key & kmask;
            klen <= klen_in;
            v    <= in_item.value & vmask;
            vlen <= vlen_in;
            res  <= '{status: ins_full ? qph_pkg::ST_FULL : qph_pkg::ST_NOT_FOUND,
                      found_value: 64'd0, found_len: 4'd0, slot_index: 10'd0};
            if (ins_full || op_bad) begin
              state <= S_FIN;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          if (hash_done) begin
            idx   <= hash_index;
            step  <= IW'(1);
            probe <= '0;
            state <= S_READ;
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          if (op == qph_pkg::OP_INSERT) begin
            if (take_slot) begin
              count          <= count + IW'(1);
              res.status     <= qph_pkg::ST_OK;
              res.slot_index <= 10'(idx);
              state          <= S_FIN;
            end else if (last_probe) begin
              res.status <= qph_pkg::ST_FULL;
              state      <= S_FIN;
            end else begin
              idx   <= idx_next;
              step  <= step_next;
              probe <= probe + IW'(1);
              state <= S_READ;
            end
          end else if (kind_rdata == qph_pkg::KIND_EMPTY) begin
            state <= S_FIN;
          end else if (is_match) begin
            res.status     <= qph_pkg::ST_OK;
            res.slot_index <= 10'(idx);
            if (op == qph_pkg::OP_REMOVE) begin
              if (count != '0) count <= count - IW'(1);
            end else begin
              res.found_value <= data_rdata.value;
              res.found_len   <= data_rdata.value_len;
            end
            state <= S_FIN;
          end else if (last_probe) begin
            state <= S_FIN;
          end else begin
            idx   <= idx_next;
            step  <= step_next;
            probe <= probe + IW'(1);
            state <= S_READ;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_item <= res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives insert, remove, lookup and unknown-op beats into the quadratic probe hash table
// core and checks every result against an in-bench table model.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TLEN = 1021;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  qph_pkg::in_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  qph_pkg::out_t out_item;

  quadratic_probe_hash_table_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
    .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow table
  logic [1:0]  tbl_kind [TLEN];
  logic [63:0] tbl_key [TLEN];
  logic [3:0]  tbl_klen [TLEN];
  logic [63:0] tbl_val [TLEN];
  logic [3:0]  tbl_vlen [TLEN];
  int unsigned tbl_count;

  qph_pkg::in_t  pending_beats[$];
  qph_pkg::out_t expected_results[$];
  int errors = 0;
  int n_ins = 0, n_rem = 0, n_look = 0, n_full = 0, n_hit = 0;
  logic calm = 1'b0;
  logic hold_off = 1'b0;
  logic in_fire = 1'b0;
  logic [63:0] key_pool [16];
  logic [3:0]  klen_pool [16];

  function automatic logic [63:0] byte_mask(int unsigned n);
    return (n >= 8) ? '1 : ((64'd1 << (n * 8)) - 64'd1);
  endfunction

  function automatic int unsigned djb2_slot(logic [63:0] k, int unsigned n);
    logic [63:0] h;
    h = qph_pkg::HASH_SEED;
    for (int i = 0; i < n; i++) h = (h << 5) + h + {56'd0, k[i*8 +: 8]};
    return 32'(h % 64'(TLEN));
  endfunction

  function automatic int find_key(logic [63:0] k, int unsigned n);
    int unsigned idx, stp;
    idx = djb2_slot(k, n);
    stp = 1;
    for (int p = 0; p < TLEN; p++) begin
      if (tbl_kind[idx] == qph_pkg::KIND_EMPTY) return -1;
      if (tbl_kind[idx] == qph_pkg::KIND_USED && tbl_klen[idx] == n && tbl_key[idx] == k)
        return int'(idx);
      idx = (idx + stp) % TLEN;
      stp += 2;
    end
    return -1;
  endfunction

  function automatic qph_pkg::out_t apply_request(qph_pkg::in_t r);
    qph_pkg::out_t o;
    int unsigned n, vn, idx, stp;
    int w;
    logic [63:0] k;
    o = '0;
    o.status = qph_pkg::ST_NOT_FOUND;
    n = (r.key_len > 4'd8) ? 32'd8 : 32'(r.key_len);
    k = r.key & byte_mask(n);
    case (r.op)
      qph_pkg::OP_INSERT: begin
        n_ins++;
        o.status = qph_pkg::ST_FULL;
        if (tbl_count < TLEN / 2) begin
          idx = djb2_slot(k, n);
          stp = 1;
          for (int p = 0; p < TLEN; p++) begin
            if (tbl_kind[idx] != qph_pkg::KIND_USED) begin
              vn = (r.value_len > 4'd8) ? 32'd8 : 32'(r.value_len);
              tbl_kind[idx] = qph_pkg::KIND_USED;
              tbl_key[idx] = k;
              tbl_klen[idx] = 4'(n);
              tbl_val[idx] = r.value & byte_mask(vn);
              tbl_vlen[idx] = 4'(vn);
              tbl_count++;
              o.status = qph_pkg::ST_OK;
              o.slot_index = 10'(idx);
              break;
            end
            idx = (idx + stp) % TLEN;
            stp += 2;
          end
        end
        if (o.status == qph_pkg::ST_FULL) n_full++;
      end
      qph_pkg::OP_REMOVE: begin
        n_rem++;
        w = find_key(k, n);
        if (w >= 0) begin
          tbl_kind[w] = qph_pkg::KIND_TOMB;
          if (tbl_count > 0) tbl_count--;
          o.status = qph_pkg::ST_OK;
          o.slot_index = 10'(w);
        end
      end
      qph_pkg::OP_LOOKUP: begin
        n_look++;
        w = find_key(k, n);
        if (w >= 0) begin
          n_hit++;
          o.status = qph_pkg::ST_OK;
          o.found_value = tbl_val[w];
          o.found_len = tbl_vlen[w];
          o.slot_index = 10'(w);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic queue_beat(logic [1:0] op, logic [63:0] k, logic [3:0] kl,
                            logic [63:0] v, logic [3:0] vl);
    qph_pkg::in_t r;
    r.op = op; r.key = k; r.key_len = kl; r.value = v; r.value_len = vl;
    pending_beats.push_back(r);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_fire) begin
        if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
          in_item <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid && pending_beats.size() > 0 &&
                   (calm || $urandom_range(99) >= 27)) begin
        in_item <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end
      out_ready <= !hold_off && (calm || $urandom_range(99) >= 27);
    end
  end

  // predictor on accept
  always @(posedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) expected_results.push_back(apply_request(in_item));
  end

  // monitor
  always @(posedge clk) begin
    qph_pkg::out_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_item.slot_index), 64'd0);
      end else begin
        e = expected_results.pop_front();
        if (out_item.status !== e.status)
          report_mismatch("status", 64'(out_item.status), 64'(e.status));
        if (out_item.found_value !== e.found_value)
          report_mismatch("found_value", out_item.found_value, e.found_value);
        if (out_item.found_len !== e.found_len)
          report_mismatch("found_len", 64'(out_item.found_len), 64'(e.found_len));
        if (out_item.slot_index !== e.slot_index)
          report_mismatch("slot_index", 64'(out_item.slot_index), 64'(e.slot_index));
      end
    end
  end

  // long receiver hold-off
  initial begin
    wait (!rst);
    repeat (3000) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #300ms;
    $display("timeout");
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int k;
    logic [1:0] op;
    for (int i = 0; i < TLEN; i++) tbl_kind[i] = qph_pkg::KIND_EMPTY;
    tbl_count = 0;
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = rand64();
      klen_pool[i] = 4'($urandom_range(1, 8));
    end
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed
    queue_beat(qph_pkg::OP_LOOKUP, 64'h1, 4'd1, 64'd0, 4'd0);
    queue_beat(qph_pkg::OP_INSERT, '0, 4'd1, '0, 4'd0);
    queue_beat(qph_pkg::OP_INSERT, '1, 4'd8, '1, 4'd8);
    queue_beat(qph_pkg::OP_INSERT, 64'hAB, 4'd0, 64'h1234, 4'd2);
    queue_beat(qph_pkg::OP_INSERT, 64'hFFFF_0000_0000_00CD, 4'd15, '1, 4'd15);
    queue_beat(qph_pkg::OP_INSERT, 64'hDEAD_BEEF_0000_0011, 4'd1, 64'hFF_FFFF, 4'd3);
    queue_beat(qph_pkg::OP_INSERT, 64'h11, 4'd1, 64'h77, 4'd1);
    queue_beat(qph_pkg::OP_LOOKUP, 64'h11, 4'd1, 64'd0, 4'd0);
    queue_beat(qph_pkg::OP_LOOKUP, 64'h0011, 4'd2, 64'd0, 4'd0);
    queue_beat(qph_pkg::OP_LOOKUP, '1, 4'd8, 64'd0, 4'd0);
    queue_beat(qph_pkg::OP_LOOKUP, 64'h0, 4'd0, 64'd0, 4'd0);
    queue_beat(qph_pkg::OP_LOOKUP, 64'h12CD, 4'd9, 64'd0, 4'd0);
    queue_beat(2'd3, '1, 4'd8, '1, 4'd8);
    queue_beat(qph_pkg::OP_REMOVE, 64'h11, 4'd1, 64'd0, 4'd0);
    queue_beat(qph_pkg::OP_LOOKUP, 64'h11, 4'd1, 64'd0, 4'd0);
    queue_beat(qph_pkg::OP_REMOVE, 64'h11, 4'd1, 64'd0, 4'd0);
    queue_beat(qph_pkg::OP_INSERT, 64'h11, 4'd1, 64'h99, 4'd8);
    queue_beat(qph_pkg::OP_LOOKUP, 64'h11, 4'd1, 64'd0, 4'd0);
    queue_beat(qph_pkg::OP_REMOVE, '1, 4'd8, '1, 4'd8);

    // fill to the full limit with random inserts, then random mix
    for (int i = 0; i < 520; i++)
      queue_beat(qph_pkg::OP_INSERT, rand64(), 4'($urandom_range(0, 15)), rand64(),
                 4'($urandom_range(0, 15)));
    for (int i = 0; i < 1000; i++) begin
      k = $urandom_range(15);
      if (i == 300) calm = 1'b1;
      if (i == 450) calm = 1'b0;
      op = $urandom_range(99) < 5 ? 2'd3 : 2'($urandom_range(2));
      if ($urandom_range(99) < 80)
        queue_beat(op, key_pool[k] ^ ({$urandom, $urandom} & ~byte_mask(klen_pool[k])),
                   klen_pool[k], rand64(), 4'($urandom_range(0, 15)));
      else
        queue_beat(op, rand64(), 4'($urandom_range(0, 15)), rand64(),
                   4'($urandom_range(0, 15)));
      while (pending_beats.size() > 40) @(posedge clk);
    end

    wait (pending_beats.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d inserts (%0d full), %0d removes, %0d lookups (%0d hits)",
             n_ins, n_full, n_rem, n_look, n_hit);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
